>>> hdl/annealing_acceptance_controller_top_assert.svh
// Assertion macros used by the checker file of the acceptance controller.
`ifndef ANNEALING_ACCEPTANCE_CONTROLLER_TOP_ASSERT_SVH
`define ANNEALING_ACCEPTANCE_CONTROLLER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on aclk, off while aresetn is low.
`define AAC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed: lbl");

// Next-cycle implication, sampled on aclk, off while aresetn is low.
`define AAC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed: lbl");

`endif

>>> hdl/aac_pkg.sv
// ----------------------------------------------------------------------------
// aac_pkg
// Shared types, codes and constants of the annealing acceptance controller.
// ----------------------------------------------------------------------------
package aac_pkg;

    localparam int EXP_TABLE_DEPTH_DEF = 256;

    // exp table recurrence: e[k] = (e[k-1] * EXP_STEP_MUL + 2^31) >> 32
    localparam logic [31:0] EXP_STEP_MUL = 32'd4034748382;
    localparam logic [16:0] EXP_ONE      = 17'd65536;

    // configuration register indexes
    localparam logic [2:0] CFG_INIT_TEMP   = 3'd0;
    localparam logic [2:0] CFG_COOLING     = 3'd1;
    localparam logic [2:0] CFG_INIT_SCALE  = 3'd2;
    localparam logic [2:0] CFG_SCALE_DECAY = 3'd3;
    localparam logic [2:0] CFG_SWEEP_LEN   = 3'd4;
    localparam logic [2:0] CFG_GAIN        = 3'd5;

    // configuration reset values
    localparam logic [31:0] INIT_TEMP_RST   = 32'd65536;
    localparam logic [15:0] COOLING_RST     = 16'd62259;
    localparam logic [31:0] INIT_SCALE_RST  = 32'd65536;
    localparam logic [15:0] SCALE_DECAY_RST = 16'd65535;
    localparam logic [15:0] SWEEP_LEN_RST   = 16'd100;
    localparam logic [31:0] GAIN_RST        = 32'd65536;

    // operations
    localparam logic OP_START = 1'b0;
    localparam logic OP_EVAL  = 1'b1;

    // result outcome codes
    localparam logic [1:0] OUT_BETTER = 2'd0;
    localparam logic [1:0] OUT_WORSE  = 2'd1;
    localparam logic [1:0] OUT_REJECT = 2'd2;
    localparam logic [1:0] OUT_START  = 2'd3;

    // controller to datapath commands
    typedef struct packed {
        logic fill;
        logic load;
        logic diff;
        logic div_init;
        logic div_step;
        logic rom_rd;
        logic decide;
        logic scale;
        logic cool;
        logic commit;
    } aac_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic fill_last;
        logic is_start;
        logic lower;
        logic skip_div;
        logic div_last;
        logic out_free;
    } aac_sts_t;

    function automatic logic [15:0] sat_inc16(input logic [15:0] v);
        sat_inc16 = (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

endpackage

>>> hdl/aac_ctrl.sv
// ----------------------------------------------------------------------------
// aac_ctrl
// Sequencer: table fill after reset, then one item at a time through the
// datapath steps.
// ----------------------------------------------------------------------------
module aac_ctrl
    import aac_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  aac_sts_t sts,
    output aac_cmd_t cmd
);

    localparam logic [3:0] S_FILL   = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_DIFF   = 4'd2;
    localparam logic [3:0] S_CHK    = 4'd3;
    localparam logic [3:0] S_DIV    = 4'd4;
    localparam logic [3:0] S_ROM    = 4'd5;
    localparam logic [3:0] S_DECIDE = 4'd6;
    localparam logic [3:0] S_SCALE  = 4'd7;
    localparam logic [3:0] S_COOL   = 4'd8;
    localparam logic [3:0] S_COMMIT = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_FILL;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            S_FILL: begin
                cmd.fill = 1'b1;
                if (sts.fill_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_DIFF;
                end
            end
            S_DIFF: begin
                if (sts.is_start) begin
                    state_next = S_COMMIT;
                end else begin
                    cmd.diff   = 1'b1;
                    state_next = S_CHK;
                end
            end
            S_CHK: begin
                cmd.div_init = 1'b1;
                if (sts.lower || sts.skip_div) begin
                    state_next = S_DECIDE;
                end else begin
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_last) begin
                    state_next = S_ROM;
                end
            end
            S_ROM: begin
                cmd.rom_rd = 1'b1;
                state_next = S_DECIDE;
            end
            S_DECIDE: begin
                cmd.decide = 1'b1;
                state_next = S_SCALE;
            end
            S_SCALE: begin
                cmd.scale  = 1'b1;
                state_next = S_COOL;
            end
            S_COOL: begin
                cmd.cool   = 1'b1;
                state_next = S_COMMIT;
            end
            S_COMMIT: begin
                if (sts.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> hdl/aac_dp.sv
// ----------------------------------------------------------------------------
// aac_dp
// Datapath: registers, energy difference multiply, restoring divider,
// exp table memory, annealing state and the result register.
// ----------------------------------------------------------------------------
module aac_dp
    import aac_pkg::*;
#(
    parameter int EXP_TABLE_DEPTH = EXP_TABLE_DEPTH_DEF
)(
    input  logic               aclk,
    input  logic               aresetn,
    input  aac_cmd_t           cmd,
    output aac_sts_t           sts,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               s_operation,
    input  logic signed [31:0] s_candidate_energy,
    input  logic [15:0]        s_random_fraction,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_outcome,
    output logic               m_revert_request,
    output logic               m_new_best,
    output logic signed [31:0] m_current_energy_out,
    output logic signed [31:0] m_best_energy_out,
    output logic [31:0]        m_temperature_out,
    output logic [31:0]        m_move_scale_out,
    output logic [31:0]        m_sweep_number,
    output logic               m_sweep_end,
    output logic [15:0]        m_sweep_accept_good,
    output logic [15:0]        m_sweep_accept_bad,
    output logic [15:0]        m_sweep_rejected
);

    localparam int IDX_W = $clog2(EXP_TABLE_DEPTH);
    localparam int Q_W   = IDX_W + 4;
    localparam int CNT_W = $clog2(Q_W + 1);

    // configuration
    logic [31:0] init_temp_reg;
    logic [15:0] cooling_reg;
    logic [31:0] init_scale_reg;
    logic [15:0] scale_decay_reg;
    logic [15:0] sweep_len_reg;
    logic [31:0] gain_reg;

    // item
    logic               op_reg;
    logic signed [31:0] cand_reg;
    logic [15:0]        rnd_reg;

    // work registers
    logic [63:0]      prod_reg;
    logic             lower_reg;
    logic [31:0]      rem_reg;
    logic [Q_W-1:0]   low_reg;
    logic [Q_W-1:0]   quo_reg;
    logic [CNT_W-1:0] bit_cnt_reg;
    logic             prob_zero_reg;
    logic [16:0]      rom_q_reg;
    logic [1:0]       outcome_reg;
    logic signed [31:0] new_cur_reg;
    logic             best_flag_reg;
    logic [47:0]      scale_prod_reg;
    logic [47:0]      temp_prod_reg;

    // annealing state
    logic signed [31:0] cur_reg;
    logic signed [31:0] best_reg;
    logic [31:0]        temp_reg;
    logic [31:0]        scale_reg;
    logic [15:0]        step_reg;
    logic [31:0]        sweep_reg;
    logic [15:0]        good_reg;
    logic [15:0]        worse_reg;
    logic [15:0]        reject_reg;

    // exp table
    logic [16:0]      exp_mem [EXP_TABLE_DEPTH];
    logic [IDX_W-1:0] fill_cnt_reg;
    logic [16:0]      fill_val_reg;
    logic [63:0]      fill_prod;
    logic [16:0]      fill_next;

    logic signed [32:0] diff;
    logic [32:0]        trial;
    logic [IDX_W-1:0]   rom_idx;
    logic               rom_in_range;
    logic               skip_div;
    logic [15:0]        good_inc;
    logic [15:0]        worse_inc;
    logic [15:0]        reject_inc;
    logic [15:0]        step_inc;
    logic               sweep_done;

    assign fill_prod = 64'(fill_val_reg) * 64'(EXP_STEP_MUL) + 64'h0000_0000_8000_0000;
    assign fill_next = fill_prod[48:32];

    assign diff         = 33'(cand_reg) - 33'(cur_reg);
    assign trial        = {rem_reg, low_reg[Q_W-1]};
    assign rom_idx      = quo_reg[Q_W-1:4];
    assign rom_in_range = 32'(rom_idx) < 32'(EXP_TABLE_DEPTH);
    assign skip_div     = (temp_reg == 32'd0) || ((prod_reg >> Q_W) >= 64'(temp_reg));

    assign good_inc   = (outcome_reg == OUT_BETTER) ? sat_inc16(good_reg) : good_reg;
    assign worse_inc  = (outcome_reg == OUT_WORSE) ? sat_inc16(worse_reg) : worse_reg;
    assign reject_inc = (outcome_reg == OUT_REJECT) ? sat_inc16(reject_reg) : reject_reg;
    assign step_inc   = sat_inc16(step_reg);
    assign sweep_done = step_inc >= sweep_len_reg;

    assign sts.fill_last = fill_cnt_reg == IDX_W'(EXP_TABLE_DEPTH - 1);
    assign sts.is_start  = op_reg == OP_START;
    assign sts.lower     = lower_reg;
    assign sts.skip_div  = skip_div;
    assign sts.div_last  = bit_cnt_reg == CNT_W'(1);
    assign sts.out_free  = !m_valid || m_ready;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            init_temp_reg   <= INIT_TEMP_RST;
            cooling_reg     <= COOLING_RST;
            init_scale_reg  <= INIT_SCALE_RST;
            scale_decay_reg <= SCALE_DECAY_RST;
            sweep_len_reg   <= SWEEP_LEN_RST;
            gain_reg        <= GAIN_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_INIT_TEMP:   init_temp_reg   <= cfg_data;
                CFG_COOLING:     cooling_reg     <= cfg_data[15:0];
                CFG_INIT_SCALE:  init_scale_reg  <= cfg_data;
                CFG_SCALE_DECAY: scale_decay_reg <= cfg_data[15:0];
                CFG_SWEEP_LEN:   sweep_len_reg   <= cfg_data[15:0];
                CFG_GAIN:        gain_reg        <= cfg_data;
                default: ;
            endcase
        end
    end

    // table fill sequence, one entry a cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_cnt_reg <= '0;
            fill_val_reg <= EXP_ONE;
        end else if (cmd.fill && !sts.fill_last) begin
            fill_cnt_reg <= fill_cnt_reg + IDX_W'(1);
            fill_val_reg <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.fill) begin
            exp_mem[fill_cnt_reg] <= fill_val_reg;
        end
        if (cmd.rom_rd && rom_in_range) begin
            rom_q_reg <= exp_mem[rom_idx];
        end
    end

    // item processing
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg   <= s_operation;
            cand_reg <= s_candidate_energy;
            rnd_reg  <= s_random_fraction;
        end
        if (cmd.diff) begin
            lower_reg <= cand_reg < cur_reg;
            prod_reg  <= 64'(diff[31:0]) * 64'(gain_reg);
        end
        if (cmd.div_init) begin
            prob_zero_reg <= skip_div;
            rem_reg       <= 32'(prod_reg >> Q_W);
            low_reg       <= prod_reg[Q_W-1:0];
            quo_reg       <= '0;
            bit_cnt_reg   <= CNT_W'(Q_W);
        end
        if (cmd.div_step) begin
            if (trial >= {1'b0, temp_reg}) begin
                rem_reg <= 32'(trial - {1'b0, temp_reg});
                quo_reg <= {quo_reg[Q_W-2:0], 1'b1};
            end else begin
                rem_reg <= trial[31:0];
                quo_reg <= {quo_reg[Q_W-2:0], 1'b0};
            end
            low_reg     <= {low_reg[Q_W-2:0], 1'b0};
            bit_cnt_reg <= bit_cnt_reg - CNT_W'(1);
        end
        if (cmd.rom_rd && !rom_in_range) begin
            prob_zero_reg <= 1'b1;
        end
        if (cmd.decide) begin
            if (lower_reg) begin
                outcome_reg   <= OUT_BETTER;
                new_cur_reg   <= cand_reg;
                best_flag_reg <= best_reg > cand_reg;
            end else if (!prob_zero_reg && (rom_q_reg > {1'b0, rnd_reg})) begin
                outcome_reg   <= OUT_WORSE;
                new_cur_reg   <= cand_reg;
                best_flag_reg <= best_reg > cand_reg;
            end else begin
                outcome_reg   <= OUT_REJECT;
                new_cur_reg   <= cur_reg;
                best_flag_reg <= best_reg > cur_reg;
            end
        end
        if (cmd.scale) begin
            scale_prod_reg <= 48'(scale_reg) * 48'(scale_decay_reg);
        end
        if (cmd.cool) begin
            temp_prod_reg <= 48'(temp_reg) * 48'(cooling_reg);
        end
    end

    // annealing state update and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_reg    <= '0;
            best_reg   <= '0;
            temp_reg   <= '0;
            scale_reg  <= '0;
            step_reg   <= '0;
            sweep_reg  <= '0;
            good_reg   <= '0;
            worse_reg  <= '0;
            reject_reg <= '0;
            m_valid    <= 1'b0;
        end else begin
            if (cmd.commit) begin
                m_valid <= 1'b1;
            end else if (m_ready) begin
                m_valid <= 1'b0;
            end
            if (cmd.commit) begin
                if (op_reg == OP_START) begin
                    cur_reg    <= cand_reg;
                    best_reg   <= cand_reg;
                    temp_reg   <= init_temp_reg;
                    scale_reg  <= init_scale_reg;
                    step_reg   <= '0;
                    sweep_reg  <= '0;
                    good_reg   <= '0;
                    worse_reg  <= '0;
                    reject_reg <= '0;
                    m_outcome            <= OUT_START;
                    m_revert_request     <= 1'b0;
                    m_new_best           <= 1'b0;
                    m_current_energy_out <= cand_reg;
                    m_best_energy_out    <= cand_reg;
                    m_temperature_out    <= init_temp_reg;
                    m_move_scale_out     <= init_scale_reg;
                    m_sweep_number       <= '0;
                    m_sweep_end          <= 1'b0;
                    m_sweep_accept_good  <= '0;
                    m_sweep_accept_bad   <= '0;
                    m_sweep_rejected     <= '0;
                end else begin
                    cur_reg              <= new_cur_reg;
                    m_outcome            <= outcome_reg;
                    m_revert_request     <= outcome_reg == OUT_REJECT;
                    m_new_best           <= best_flag_reg;
                    m_current_energy_out <= new_cur_reg;
                    if (best_flag_reg) begin
                        best_reg          <= new_cur_reg;
                        scale_reg         <= scale_prod_reg[47:16];
                        m_best_energy_out <= new_cur_reg;
                        m_move_scale_out  <= scale_prod_reg[47:16];
                    end else begin
                        m_best_energy_out <= best_reg;
                        m_move_scale_out  <= scale_reg;
                    end
                    m_sweep_end <= sweep_done;
                    if (sweep_done) begin
                        temp_reg            <= temp_prod_reg[47:16];
                        m_temperature_out   <= temp_prod_reg[47:16];
                        sweep_reg           <= (sweep_reg == '1) ? sweep_reg
                                                                 : sweep_reg + 32'd1;
                        m_sweep_number      <= (sweep_reg == '1) ? sweep_reg
                                                                 : sweep_reg + 32'd1;
                        step_reg            <= '0;
                        good_reg            <= '0;
                        worse_reg           <= '0;
                        reject_reg          <= '0;
                        m_sweep_accept_good <= good_inc;
                        m_sweep_accept_bad  <= worse_inc;
                        m_sweep_rejected    <= reject_inc;
                    end else begin
                        m_temperature_out   <= temp_reg;
                        m_sweep_number      <= sweep_reg;
                        step_reg            <= step_inc;
                        good_reg            <= good_inc;
                        worse_reg           <= worse_inc;
                        reject_reg          <= reject_inc;
                        m_sweep_accept_good <= '0;
                        m_sweep_accept_bad  <= '0;
                        m_sweep_rejected    <= '0;
                    end
                end
            end
        end
    end

endmodule

>>> hdl/annealing_acceptance_controller_top.sv
// Metropolis acceptance controller for simulated annealing with geometric cooling.
// Input channel s_*: one transaction per start (operation 0) or candidate (1).
// Result channel m_*: exactly one result transaction per input transaction, in order.
// Configuration channel cfg_*: index 0..5 selects the register, cfg_data carries
// the value; cfg_ready is always high and unknown indexes are dropped.
// Throughput: one item at a time. A candidate that needs the exp table runs through
// the bit-serial restoring divider, with Q = log2(EXP_TABLE_DEPTH) + 4 quotient bits,
// then the table read; a strictly lower energy, a zero temperature or an exponent
// beyond the table skips the divider and table, and a start goes straight to the
// result. Result valid rises in the cycle after the final step of the item.
// Reset: synchronous on aresetn low; configuration registers return to their
// defaults, state clears, and the exp table is then rebuilt entry by entry, during
// which s_ready stays low (configuration writes are still taken).
// Receiver stall: the result register holds; the next item is accepted and worked
// on, and its result waits in the last step until the register frees up.
// ----------------------------------------------------------------------------
// annealing_acceptance_controller_top
// Top level: sequencer plus datapath.
// ----------------------------------------------------------------------------
module annealing_acceptance_controller_top
    import aac_pkg::*;
#(
    parameter int EXP_TABLE_DEPTH = EXP_TABLE_DEPTH_DEF
)(
    input  logic               aclk,
    input  logic               aresetn,
    // configuration write channel
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    // input channel
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_operation,
    input  logic signed [31:0] s_candidate_energy,
    input  logic [15:0]        s_random_fraction,
    // result channel
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_outcome,
    output logic               m_revert_request,
    output logic               m_new_best,
    output logic signed [31:0] m_current_energy_out,
    output logic signed [31:0] m_best_energy_out,
    output logic [31:0]        m_temperature_out,
    output logic [31:0]        m_move_scale_out,
    output logic [31:0]        m_sweep_number,
    output logic               m_sweep_end,
    output logic [15:0]        m_sweep_accept_good,
    output logic [15:0]        m_sweep_accept_bad,
    output logic [15:0]        m_sweep_rejected
);

    aac_cmd_t cmd;
    aac_sts_t sts;

    // configuration is always writable; the host must write only while idle, not enforced here
    assign cfg_ready = 1'b1;

    // sequencer: fill the table, then step each transaction through the datapath
    aac_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // datapath: arithmetic, table, state and the result register
    aac_dp #(
        .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
    ) u_dp (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cmd                  (cmd),
        .sts                  (sts),
        .cfg_we               (cfg_valid && cfg_ready),
        .cfg_index            (cfg_index),
        .cfg_data             (cfg_data),
        .s_operation          (s_operation),
        .s_candidate_energy   (s_candidate_energy),
        .s_random_fraction    (s_random_fraction),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_outcome            (m_outcome),
        .m_revert_request     (m_revert_request),
        .m_new_best           (m_new_best),
        .m_current_energy_out (m_current_energy_out),
        .m_best_energy_out    (m_best_energy_out),
        .m_temperature_out    (m_temperature_out),
        .m_move_scale_out     (m_move_scale_out),
        .m_sweep_number       (m_sweep_number),
        .m_sweep_end          (m_sweep_end),
        .m_sweep_accept_good  (m_sweep_accept_good),
        .m_sweep_accept_bad   (m_sweep_accept_bad),
        .m_sweep_rejected     (m_sweep_rejected)
    );

endmodule

>>> hdl/aac_checker.sv
// ----------------------------------------------------------------------------
// aac_checker
// Port-level checks on the result channel of the acceptance controller.
// ----------------------------------------------------------------------------
`include "annealing_acceptance_controller_top_assert.svh"

module aac_checker
    import aac_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [1:0]  m_outcome,
    input logic        m_revert_request,
    input logic        m_new_best,
    input logic [31:0] m_sweep_number,
    input logic        m_sweep_end,
    input logic [15:0] m_sweep_accept_good,
    input logic [15:0] m_sweep_accept_bad,
    input logic [15:0] m_sweep_rejected
);

    `AAC_ASSERT_NXT(a_result_holds, m_valid && !m_ready, m_valid && $stable(m_outcome))
    `AAC_ASSERT_IMP(a_revert_on_reject, m_valid, m_revert_request == (m_outcome == OUT_REJECT))
    `AAC_ASSERT_IMP(a_start_clean, m_valid && m_outcome == OUT_START, !m_new_best && !m_sweep_end && m_sweep_number == 32'd0)
    `AAC_ASSERT_IMP(a_counts_only_at_end, m_valid && !m_sweep_end, m_sweep_accept_good == 16'd0 && m_sweep_accept_bad == 16'd0 && m_sweep_rejected == 16'd0)

endmodule

bind annealing_acceptance_controller_top aac_checker u_aac_checker (.*);
